FILE: design/dntr_pkg.sv
// ----------------------------------------------------------------------------
// dntr_pkg
// types, character codes and scan phase codes for the decimal number text
// recogniser
// ----------------------------------------------------------------------------
package dntr_pkg;

   typedef logic [7:0] char_type;
   typedef logic [3:0] phase_type;

   localparam char_type CHAR_NUL   = 8'h00;
   localparam char_type CHAR_TAB   = 8'h09;
   localparam char_type CHAR_CR    = 8'h0D;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_PLUS  = 8'h2B;
   localparam char_type CHAR_MINUS = 8'h2D;
   localparam char_type CHAR_DOT   = 8'h2E;
   localparam char_type CHAR_ZERO  = 8'h30;
   localparam char_type CHAR_NINE  = 8'h39;
   localparam char_type CHAR_E     = 8'h65;

   localparam phase_type PH_LEAD    = 4'd0;
   localparam phase_type PH_SIGN    = 4'd1;
   localparam phase_type PH_INT     = 4'd2;
   localparam phase_type PH_DOT     = 4'd3;
   localparam phase_type PH_FRAC    = 4'd4;
   localparam phase_type PH_EXP     = 4'd5;
   localparam phase_type PH_EXPSIGN = 4'd6;
   localparam phase_type PH_EXPDIG  = 4'd7;
   localparam phase_type PH_TRAIL   = 4'd8;
   localparam phase_type PH_REJECT  = 4'd9;

endpackage

FILE: design/decimal_number_text_recognizer_core.sv
// output: a verdict appears in the cycle after the transaction carrying the NUL
// throughput: one character per cycle; input stalls only while a verdict is
// held back by rsp_stall
// reset: synchronous, returns the scanner to the leading whitespace phase and
// empties the verdict register
// ----------------------------------------------------------------------------
// decimal_number_text_recognizer_core
// scans number text one character per transaction and gives one verdict per
// NUL-terminated string
// ----------------------------------------------------------------------------
module decimal_number_text_recognizer_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dntr_pkg::char_type req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_is_numeric
);
   import dntr_pkg::*;

   phase_type phase_ff, phase_in;
   logic      integer_seen_ff, integer_seen_in;
   logic      mantissa_seen_ff, mantissa_seen_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_is_numeric_ff, rsp_is_numeric_in;

   logic req_accept;
   logic is_nul, is_ws, is_dig, is_sign, is_dot, is_e;
   logic verdict;
   phase_type on_e;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign is_nul  = (req_char_code == CHAR_NUL);
   assign is_ws   = (req_char_code == CHAR_SPACE) ||
                    ((req_char_code >= CHAR_TAB) && (req_char_code <= CHAR_CR));
   assign is_dig  = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
   assign is_sign = (req_char_code == CHAR_PLUS) || (req_char_code == CHAR_MINUS);
   assign is_dot  = (req_char_code == CHAR_DOT);
   assign is_e    = (req_char_code == CHAR_E);
   assign on_e    = mantissa_seen_ff ? PH_EXP : PH_REJECT;

   // verdict for the phase in which the string ends
   always_comb begin
      unique case (phase_ff)
         PH_SIGN, PH_INT, PH_FRAC, PH_EXPDIG, PH_TRAIL: verdict = 1'b1;
         PH_DOT:  verdict = integer_seen_ff;
         default: verdict = 1'b0;
      endcase
   end

   always_comb begin
      phase_in          = phase_ff;
      integer_seen_in   = integer_seen_ff;
      mantissa_seen_in  = mantissa_seen_ff;
      rsp_valid_in      = rsp_valid_ff & rsp_stall;
      rsp_is_numeric_in = rsp_is_numeric_ff;
      if (req_accept && is_nul) begin
         rsp_valid_in      = 1'b1;
         rsp_is_numeric_in = verdict;
         phase_in          = PH_LEAD;
         integer_seen_in   = 1'b0;
         mantissa_seen_in  = 1'b0;
      end else if (req_accept) begin
         unique case (phase_ff)
            PH_LEAD, PH_SIGN: begin
               if (phase_ff == PH_LEAD && is_ws) begin
                  phase_in = PH_LEAD;
               end else if (phase_ff == PH_LEAD && is_sign) begin
                  phase_in = PH_SIGN;
               end else if (is_dig) begin
                  phase_in         = PH_INT;
                  integer_seen_in  = 1'b1;
                  mantissa_seen_in = 1'b1;
               end else if (is_dot) begin
                  phase_in = PH_DOT;
               end else if (phase_ff == PH_SIGN && is_ws) begin
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_REJECT;
               end
            end
            PH_INT: begin
               if (is_dig)      phase_in = PH_INT;
               else if (is_dot) phase_in = PH_DOT;
               else if (is_e)   phase_in = on_e;
               else if (is_ws)  phase_in = PH_TRAIL;
               else             phase_in = PH_REJECT;
            end
            PH_DOT, PH_FRAC: begin
               if (is_dig) begin
                  phase_in         = PH_FRAC;
                  mantissa_seen_in = 1'b1;
               end else if (phase_ff == PH_DOT && !integer_seen_ff) begin
                  phase_in = PH_REJECT;
               end else if (is_e) begin
                  phase_in = on_e;
               end else if (is_ws) begin
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_REJECT;
               end
            end
            PH_EXP: begin
               if (is_sign)     phase_in = PH_EXPSIGN;
               else if (is_dig) phase_in = PH_EXPDIG;
               else             phase_in = PH_REJECT;
            end
            PH_EXPSIGN: begin
               phase_in = is_dig ? PH_EXPDIG : PH_REJECT;
            end
            PH_EXPDIG: begin
               if (is_dig)     phase_in = PH_EXPDIG;
               else if (is_ws) phase_in = PH_TRAIL;
               else            phase_in = PH_REJECT;
            end
            PH_TRAIL: begin
               phase_in = is_ws ? PH_TRAIL : PH_REJECT;
            end
            default: begin
               phase_in = PH_REJECT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_LEAD;
         integer_seen_ff  <= 1'b0;
         mantissa_seen_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         integer_seen_ff  <= integer_seen_in;
         mantissa_seen_ff <= mantissa_seen_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // verdict payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_is_numeric_ff <= rsp_is_numeric_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_numeric = rsp_is_numeric_ff;

endmodule

FILE: verif/decimal_number_text_recognizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_text_recognizer_core_tb
// self-checking bench: characters go in on the request channel with random
// gaps, verdicts come back under random stalls and are compared against a
// scan phase predictor kept in a small scoreboard
// ----------------------------------------------------------------------------
module decimal_number_text_recognizer_core_tb;
   import dntr_pkg::*;

   localparam char_type CHAR_LF     = 8'h0A;
   localparam char_type CHAR_VT     = 8'h0B;
   localparam char_type CHAR_FF     = 8'h0C;
   localparam int       CYCLE_LIMIT = 400000;
   localparam int       REPORT_MAX  = 10;

   class verdict_scoreboard;
      phase_type scan_phase    = PH_LEAD;
      bit        integer_seen  = 1'b0;
      bit        mantissa_seen = 1'b0;
      bit        pending_verdicts[$];
      int        mismatches    = 0;

      function bit is_blank(char_type c);
         return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
      endfunction

      function bit is_digit(char_type c);
         return c >= CHAR_ZERO && c <= CHAR_NINE;
      endfunction

      function bit is_sign(char_type c);
         return c == CHAR_PLUS || c == CHAR_MINUS;
      endfunction

      function phase_type after_e();
         return mantissa_seen ? PH_EXP : PH_REJECT;
      endfunction

      function phase_type next_scan_phase(phase_type ph, char_type c);
         case (ph)
            PH_LEAD, PH_SIGN: begin
               if (ph == PH_LEAD && is_blank(c)) return PH_LEAD;
               if (ph == PH_LEAD && is_sign(c)) return PH_SIGN;
               if (is_digit(c)) begin
                  integer_seen  = 1'b1;
                  mantissa_seen = 1'b1;
                  return PH_INT;
               end
               if (c == CHAR_DOT) return PH_DOT;
               if (ph == PH_SIGN && is_blank(c)) return PH_TRAIL;
               return PH_REJECT;
            end
            PH_INT: begin
               if (is_digit(c)) return PH_INT;
               if (c == CHAR_DOT) return PH_DOT;
               if (c == CHAR_E) return after_e();
               if (is_blank(c)) return PH_TRAIL;
               return PH_REJECT;
            end
            PH_DOT, PH_FRAC: begin
               if (is_digit(c)) begin
                  mantissa_seen = 1'b1;
                  return PH_FRAC;
               end
               if (ph == PH_DOT && !integer_seen) return PH_REJECT;
               if (c == CHAR_E) return after_e();
               if (is_blank(c)) return PH_TRAIL;
               return PH_REJECT;
            end
            PH_EXP, PH_EXPSIGN: begin
               if (ph == PH_EXP && is_sign(c)) return PH_EXPSIGN;
               return is_digit(c) ? PH_EXPDIG : PH_REJECT;
            end
            PH_EXPDIG: begin
               if (is_digit(c)) return PH_EXPDIG;
               if (is_blank(c)) return PH_TRAIL;
               return PH_REJECT;
            end
            PH_TRAIL: return is_blank(c) ? PH_TRAIL : PH_REJECT;
            default:  return PH_REJECT;
         endcase
      endfunction

      function bit final_verdict();
         case (scan_phase)
            PH_SIGN, PH_INT, PH_FRAC, PH_EXPDIG, PH_TRAIL: return 1'b1;
            PH_DOT:  return integer_seen;
            default: return 1'b0;
         endcase
      endfunction

      function void note_char(char_type c);
         if (c == CHAR_NUL) begin
            pending_verdicts.push_back(final_verdict());
            scan_phase    = PH_LEAD;
            integer_seen  = 1'b0;
            mantissa_seen = 1'b0;
         end else begin
            scan_phase = next_scan_phase(scan_phase, c);
         end
      endfunction

      function void check_verdict(bit got);
         bit want;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected verdict: is_numeric=%0d", got);
            return;
         end
         want = pending_verdicts.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("verdict mismatch: expected is_numeric=%0d, got %0d", want, got);
         end
      endfunction
   endclass

   logic     clock         = 1'b0;
   logic     reset         = 1'b1;
   logic     req_valid     = 1'b0;
   logic     req_stall;
   char_type req_char_code = CHAR_NUL;
   logic     rsp_valid;
   logic     rsp_stall     = 1'b0;
   logic     rsp_is_numeric;

   verdict_scoreboard board = new();
   char_type          text_buf[$];
   int                tx_idle_pct = 0;
   int                rx_idle_pct = 0;
   int                cycle_count = 0;

   decimal_number_text_recognizer_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_numeric (rsp_is_numeric)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_verdict(rsp_is_numeric);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic drive_char(char_type c);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (req_stall);
      board.note_char(c);
   endtask

   task automatic drive_string(string s);
      for (int i = 0; i < s.len(); i++)
         drive_char(char_type'(s[i]));
   endtask

   task automatic drive_text_buf();
      foreach (text_buf[i])
         drive_char(text_buf[i]);
      drive_char(CHAR_NUL);
   endtask

   function automatic char_type random_blank();
      case ($urandom_range(0, 5))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_LF;
         3:       return CHAR_VT;
         4:       return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   function automatic char_type random_sign();
      return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
   endfunction

   function automatic char_type random_digit();
      return CHAR_ZERO + char_type'($urandom_range(0, 9));
   endfunction

   function automatic void build_random_text();
      int kind;
      kind = $urandom_range(0, 9);
      text_buf.delete();
      if (kind == 0) begin
         repeat ($urandom_range(0, 6)) text_buf.push_back(char_type'($urandom_range(1, 255)));
         return;
      end
      repeat ($urandom_range(0, 2)) text_buf.push_back(random_blank());
      if ($urandom_range(0, 2) == 0) text_buf.push_back(random_sign());
      repeat ($urandom_range(0, 3)) text_buf.push_back(random_digit());
      if ($urandom_range(0, 1)) begin
         text_buf.push_back(CHAR_DOT);
         repeat ($urandom_range(0, 3)) text_buf.push_back(random_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
         text_buf.push_back(CHAR_E);
         if ($urandom_range(0, 1)) text_buf.push_back(random_sign());
         repeat ($urandom_range(0, 2)) text_buf.push_back(random_digit());
      end
      repeat ($urandom_range(0, 2)) text_buf.push_back(random_blank());
      // corrupt or shorten a well-formed text now and then
      if (kind == 1 && text_buf.size() > 0)
         text_buf[$urandom_range(0, text_buf.size() - 1)] = char_type'($urandom_range(1, 255));
      if (kind == 2 && text_buf.size() > 0)
         text_buf.delete($urandom_range(0, text_buf.size() - 1));
   endfunction

   task automatic random_texts(int char_budget);
      int sent;
      sent = 0;
      while (sent < char_budget) begin
         build_random_text();
         sent += text_buf.size() + 1;
         drive_text_buf();
      end
   endtask

   initial begin
      string directed[$];
      directed = '{"", "  ", "+", "- ", "0", "+9", "12.", ".5", "-3.25e+7 ", ".", ". ",
                   "+.", ".e1", "e5", "1e", "1e- ", "1E5", "7.e-0", "1.2.3", "1x 2",
                   "  42  ", "9e9x"};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         drive_string(directed[i]);
         drive_char(CHAR_NUL);
      end
      // every blank character on both sides of a number
      text_buf = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR, CHAR_NINE,
                   CHAR_CR, CHAR_FF, CHAR_VT, CHAR_LF, CHAR_TAB, CHAR_SPACE};
      drive_text_buf();
      // high bytes reject, everything up to the nul is ignored
      text_buf = '{CHAR_ZERO, 8'h80, CHAR_ZERO};
      drive_text_buf();
      text_buf = '{8'hFF};
      drive_text_buf();

      tx_idle_pct = 25;
      rx_idle_pct = 68;
      random_texts(300);
      tx_idle_pct = 68;
      rx_idle_pct = 25;
      random_texts(300);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_texts(300);

      req_valid <= 1'b0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
